[hw/rtl/dlr_pkg.sv]
// Shared types and constants for the DDA line rasterizer.
// Used by every module of the block but dlr_divider; depends on nothing.

package dlr_pkg;

  // Depth of the segment queue between front end and stepper.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RUN
  } step_state_t;

endpackage

[hw/rtl/dlr_front.sv]
// Front end of the DDA line rasterizer: takes segments, works out the deltas
// and the step count, drops zero-length segments and queues the rest.
// Depends on dlr_pkg.

module dlr_front
  import dlr_pkg::*;
#(
  parameter int COORD_BITS = 6,
  parameter int IN_W       = 24,
  parameter int ENTRY_W    = 32
) (
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [IN_W-1:0]    in_tdata,
  input  fifo_stat_t         fifo_stat,
  output logic               push,
  output logic [ENTRY_W-1:0] push_data
);

  localparam int C = COORD_BITS;

  logic [C-1:0] xs, ys, xe, ye;
  logic [C:0]   dx, dy;
  logic [C-1:0] adx, ady, n;
  logic         sx, sy;

  assign xs = in_tdata[0 +: C];
  assign ys = in_tdata[C +: C];
  assign xe = in_tdata[2*C +: C];
  assign ye = in_tdata[3*C +: C];

  always_comb begin
    dx  = {1'b0, xe} - {1'b0, xs};
    dy  = {1'b0, ye} - {1'b0, ys};
    sx  = dx[C];
    sy  = dy[C];
    adx = sx ? C'((~dx) + 1'b1) : dx[C-1:0];
    ady = sy ? C'((~dy) + 1'b1) : dy[C-1:0];
    n   = (adx > ady) ? adx : ady;
  end

  assign in_tready = ~fifo_stat.full;

  // A zero-length segment is taken from the input and produces nothing.
  assign push      = in_tvalid & in_tready & (n != '0);
  assign push_data = {n, sy, sx, ady, adx, ys, xs};

endmodule

[hw/rtl/dlr_fifo.sv]
// Short segment queue that decouples the front end from the stepper.
// Depends on dlr_pkg.

module dlr_fifo
  import dlr_pkg::*;
#(
  parameter int ENTRY_W = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [ENTRY_W-1:0] push_data,
  input  logic               pop,
  output logic [ENTRY_W-1:0] head_data,
  output fifo_stat_t         stat
);

  logic [ENTRY_W-1:0]    mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;

  assign stat.full  = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head_data  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

endmodule

[hw/rtl/dlr_divider.sv]
// Restoring divider that forms both increment magnitudes, one quotient bit
// per cycle: (mag << FRACTION_BITS) / den with mag <= den. Needs no package.

module dlr_divider #(
  parameter int COORD_BITS    = 6,
  parameter int FRACTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [COORD_BITS-1:0]  mag_x,
  input  logic [COORD_BITS-1:0]  mag_y,
  input  logic [COORD_BITS-1:0]  den,
  output logic                   done,
  output logic [FRACTION_BITS:0] quo_x,
  output logic [FRACTION_BITS:0] quo_y
);

  localparam int C  = COORD_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int CW = $clog2(F + 1);

  logic [C-1:0]  den_r, rx_r, ry_r, rx_nxt, ry_nxt;
  logic [F:0]    qx_r, qy_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, first_r, done_r;
  logic [C:0]    trial_x, trial_y, diff_x, diff_y;
  logic          ge_x, ge_y;

  // The first step yields the integer bit; the remainder is not doubled.
  always_comb begin
    trial_x = first_r ? {1'b0, rx_r} : {rx_r, 1'b0};
    trial_y = first_r ? {1'b0, ry_r} : {ry_r, 1'b0};
    ge_x    = (trial_x >= {1'b0, den_r});
    ge_y    = (trial_y >= {1'b0, den_r});
    diff_x  = trial_x - {1'b0, den_r};
    diff_y  = trial_y - {1'b0, den_r};
    rx_nxt  = ge_x ? diff_x[C-1:0] : trial_x[C-1:0];
    ry_nxt  = ge_y ? diff_y[C-1:0] : trial_y[C-1:0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rx_r  <= mag_x;
      ry_r  <= mag_y;
    end else if (busy_r) begin
      rx_r <= rx_nxt;
      ry_r <= ry_nxt;
      qx_r <= {qx_r[F-1:0], ge_x};
      qy_r <= {qy_r[F-1:0], ge_y};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      first_r <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        first_r <= 1'b1;
        cnt_r   <= '0;
      end else if (busy_r) begin
        first_r <= 1'b0;
        cnt_r   <= cnt_r + 1'b1;
        if (cnt_r == CW'(F)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign quo_x = qx_r;
  assign quo_y = qy_r;

endmodule

[hw/rtl/dlr_stepper.sv]
// Back end of the DDA line rasterizer: pops a segment, runs the divider and
// then steps the accumulators, one pixel per transfer. Depends on dlr_pkg
// and dlr_divider.

module dlr_stepper
  import dlr_pkg::*;
#(
  parameter int COORD_BITS    = 6,
  parameter int FRACTION_BITS = 16,
  parameter int ENTRY_W       = 32,
  parameter int OUT_W         = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fifo_stat_t         fifo_stat,
  input  logic [ENTRY_W-1:0] head_data,
  output logic               pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata,
  output logic               out_tlast
);

  localparam int C  = COORD_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int AW = C + F;

  step_state_t state_r, state_nxt;

  logic [C-1:0]  h_xs, h_ys, h_adx, h_ady, h_n;
  logic          h_sx, h_sy;
  logic [C-1:0]  xs_r, ys_r, steps_r;
  logic          sx_r, sy_r;
  logic [AW-1:0] acc_x_r, acc_y_r, inc_x_r, inc_y_r, qx_ext, qy_ext;
  logic          div_done, load, emit;
  logic [F:0]    quo_x, quo_y;
  logic          out_valid_r, last_r;
  logic [C-1:0]  pix_x_r, pix_y_r;

  assign h_xs  = head_data[0 +: C];
  assign h_ys  = head_data[C +: C];
  assign h_adx = head_data[2*C +: C];
  assign h_ady = head_data[3*C +: C];
  assign h_sx  = head_data[4*C];
  assign h_sy  = head_data[4*C+1];
  assign h_n   = head_data[4*C+2 +: C];

  dlr_divider #(
    .COORD_BITS    (C),
    .FRACTION_BITS (F)
  ) u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pop),
    .mag_x (h_adx),
    .mag_y (h_ady),
    .den   (h_n),
    .done  (div_done),
    .quo_x (quo_x),
    .quo_y (quo_y)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!fifo_stat.empty) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (emit && (steps_r == C'(1))) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop  = 1'b0;
    load = 1'b0;
    emit = 1'b0;
    unique case (state_r)
      ST_IDLE: pop  = ~fifo_stat.empty;
      ST_DIV:  load = div_done;
      ST_RUN:  emit = ~out_valid_r | out_tready;
      default: ;
    endcase
  end

  assign qx_ext = {{(AW-F-1){1'b0}}, quo_x};
  assign qy_ext = {{(AW-F-1){1'b0}}, quo_y};

  always_ff @(posedge clk) begin
    if (pop) begin
      xs_r    <= h_xs;
      ys_r    <= h_ys;
      sx_r    <= h_sx;
      sy_r    <= h_sy;
      steps_r <= h_n;
    end
    // Positions wrap modulo 2^(COORD_BITS+FRACTION_BITS); only the integer
    // bits inside that range are ever shown.
    if (load) begin
      acc_x_r <= {xs_r, {F{1'b0}}};
      acc_y_r <= {ys_r, {F{1'b0}}};
      inc_x_r <= sx_r ? AW'(0) - qx_ext : qx_ext;
      inc_y_r <= sy_r ? AW'(0) - qy_ext : qy_ext;
    end else if (emit) begin
      acc_x_r <= acc_x_r + inc_x_r;
      acc_y_r <= acc_y_r + inc_y_r;
      steps_r <= steps_r - 1'b1;
    end
    if (emit) begin
      pix_x_r <= acc_x_r[F +: C];
      pix_y_r <= acc_y_r[F +: C];
      last_r  <= (steps_r == C'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {{(OUT_W-2*C){1'b0}}, pix_y_r, pix_x_r};

endmodule

[hw/rtl/dda_line_rasterizer.sv]
// DDA line rasterizer, top level.
// Slave stream in_*: one segment per transfer. in_tdata from the lowest bit:
// x_start, y_start, x_end, y_end, COORD_BITS each, zero padded to bytes.
// Master stream out_*: one pixel per transfer, out_tdata from the lowest bit:
// pixel_x, pixel_y, zero padded; out_tlast marks the final pixel of a run.
// A segment of length n = max(|dx|, |dy|) yields n pixels from the start
// point, never the end point; a zero-length segment yields none.
// The front end queues up to two segments, so input is taken while the
// stepper works. Per segment the stepper pops the entry, then waits for the
// shared bit-serial divider, which forms both increments one quotient bit
// per cycle, then steps out one pixel per transfer while the receiver takes
// them; it pops the next segment only after the last pixel of this one.
// With the stepper idle, a segment passes the queue, the pop, the divider and
// the accumulator load before its first pixel enters the output register.
// When the receiver stalls, the output register holds its pixel and the
// stepper waits; the queue then fills and in_tready falls.
// Reset (rst_n low, synchronous) empties the queue and the output register.
// Depends on dlr_pkg, dlr_front, dlr_fifo, dlr_divider and dlr_stepper.

module dda_line_rasterizer
  import dlr_pkg::*;
#(
  parameter int COORD_BITS    = 6,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // x_start, y_start, x_end, y_end from the lowest bit up
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]        in_tdata,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // pixel_x, pixel_y from the lowest bit up
  output logic [((2*COORD_BITS+7)/8)*8-1:0]        out_tdata,
  output logic                                     out_tlast
);

  localparam int IN_W    = ((4*COORD_BITS+7)/8)*8;
  localparam int OUT_W   = ((2*COORD_BITS+7)/8)*8;
  localparam int ENTRY_W = 5*COORD_BITS + 2;

  fifo_stat_t         fifo_stat;
  logic               push, pop;
  logic [ENTRY_W-1:0] push_data, head_data;

  dlr_front #(
    .COORD_BITS (COORD_BITS),
    .IN_W       (IN_W),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_data (push_data)
  );

  dlr_fifo #(
    .ENTRY_W (ENTRY_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .stat      (fifo_stat)
  );

  dlr_stepper #(
    .COORD_BITS    (COORD_BITS),
    .FRACTION_BITS (FRACTION_BITS),
    .ENTRY_W       (ENTRY_W),
    .OUT_W         (OUT_W)
  ) u_stepper (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_stat  (fifo_stat),
    .head_data  (head_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[tb/testbench.sv]
// Self-checking testbench for the DDA line rasterizer: it drives segments on the input stream
// and checks every pixel against a local stepping model of the increments and floor logic.
// Depends only on the dda_line_rasterizer RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int COORD_W       = 6;
  localparam int FRAC_W        = 16;
  localparam int ACC_W         = 23;
  localparam int INC_W         = 18;
  localparam int IN_W          = ((4*COORD_W+7)/8)*8;
  localparam int OUT_W         = ((2*COORD_W+7)/8)*8;
  localparam int COORD_MAX     = (1 << COORD_W) - 1;
  localparam int MAX_IDLE      = 12;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 1_500_000;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;

  pixel_t expected_pixels[$];
  int     error_count     = 0;
  int     cycle_count     = 0;
  bit     sender_idles    = 1'b1;
  bit     receiver_idles  = 1'b1;

  dda_line_rasterizer #(
    .COORD_BITS   (COORD_W),
    .FRACTION_BITS(FRAC_W)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // Signed per-step increment d / n with FRAC_W fraction bits, truncated toward zero.
  function automatic logic signed [INC_W-1:0] step_increment(input int d, input int n);
    int mag;
    int q;
    mag = (d < 0) ? -d : d;
    q = (mag << FRAC_W) / n;
    return (d < 0) ? INC_W'(-q) : INC_W'(q);
  endfunction

  // Works out the pixel run of one segment and queues it.
  task automatic rasterize_segment(input coord_t xs, ys, xe, ye);
    int dx;
    int dy;
    int steps;
    logic signed [ACC_W-1:0] acc_x;
    logic signed [ACC_W-1:0] acc_y;
    logic signed [ACC_W-1:0] pos_x;
    logic signed [ACC_W-1:0] pos_y;
    logic signed [INC_W-1:0] inc_x;
    logic signed [INC_W-1:0] inc_y;
    pixel_t pix;
    dx = int'(xe) - int'(xs);
    dy = int'(ye) - int'(ys);
    steps = (dx < 0) ? -dx : dx;
    if (((dy < 0) ? -dy : dy) > steps) begin
      steps = (dy < 0) ? -dy : dy;
    end
    if (steps == 0) begin
      return;
    end
    inc_x = step_increment(dx, steps);
    inc_y = step_increment(dy, steps);
    acc_x = ACC_W'({xs, {FRAC_W{1'b0}}});
    acc_y = ACC_W'({ys, {FRAC_W{1'b0}}});
    for (int left = steps; left > 0; left--) begin
      // An arithmetic shift of the accumulator is its floor.
      pos_x = acc_x >>> FRAC_W;
      pos_y = acc_y >>> FRAC_W;
      pix.x = pos_x[COORD_W-1:0];
      pix.y = pos_y[COORD_W-1:0];
      pix.last = (left == 1);
      expected_pixels.push_back(pix);
      acc_x = acc_x + ACC_W'(inc_x);
      acc_y = acc_y + ACC_W'(inc_y);
    end
  endtask

  task automatic send_segment(input coord_t xs, ys, xe, ye);
    int gap;
    gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({ye, xe, ys, xs});
    do @(posedge clk); while (in_tready !== 1'b1);
    rasterize_segment(xs, ys, xe, ye);
  endtask

  function automatic coord_t nudge(input coord_t c);
    int v;
    v = int'(c) + int'($urandom_range(0, 8)) - 4;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return coord_t'(v);
  endfunction

  function automatic coord_t random_coord();
    return coord_t'($urandom_range(0, COORD_MAX));
  endfunction

  function automatic coord_t random_corner();
    return ($urandom_range(0, 1) != 0) ? coord_t'(COORD_MAX) : coord_t'(0);
  endfunction

  // Arbitrary segments in half the draws, the rest short, zero-length or corner-to-corner ones.
  task automatic send_random_segment();
    int kind;
    coord_t xs;
    coord_t ys;
    kind = $urandom_range(0, 9);
    xs = random_coord();
    ys = random_coord();
    case (kind)
      5, 6, 7: begin
        send_segment(xs, ys, nudge(xs), nudge(ys));
      end
      8: begin
        send_segment(xs, ys, xs, ys);
      end
      9: begin
        send_segment(random_corner(), random_corner(), random_corner(), random_corner());
      end
      default: begin
        send_segment(xs, ys, random_coord(), random_coord());
      end
    endcase
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic check_pixel(input logic [OUT_W-1:0] data, input logic last);
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      report_mismatch($sformatf("pixel (%0d,%0d) arrived with none expected",
                                data[COORD_W-1:0], data[2*COORD_W-1:COORD_W]));
      return;
    end
    want = expected_pixels.pop_front();
    if (data[COORD_W-1:0] !== want.x) begin
      report_mismatch($sformatf("pixel_x %0d, expected %0d", data[COORD_W-1:0], want.x));
    end
    if (data[2*COORD_W-1:COORD_W] !== want.y) begin
      report_mismatch($sformatf("pixel_y %0d, expected %0d",
                                data[2*COORD_W-1:COORD_W], want.y));
    end
    if (last !== want.last) begin
      report_mismatch($sformatf("last_pixel %b, expected %b", last, want.last));
    end
    if (data[OUT_W-1:2*COORD_W] !== '0) begin
      report_mismatch($sformatf("out_tdata padding %h is not zero", data[OUT_W-1:2*COORD_W]));
    end
  endtask

  // Pixel receiver: random stalls before each transfer while receiver_idles is set, checked in arrival order.
  initial begin : pixel_sink
    int stall;
    out_tready = 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = receiver_idles ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      check_pixel(out_tdata, out_tlast);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: errors");
    $finish;
  end

  task automatic test_directed_segments();
    // Zero-length segments at both ends of the range and in the middle.
    send_segment(0, 0, 0, 0);
    send_segment(63, 63, 63, 63);
    send_segment(17, 40, 17, 40);
    // Full-length diagonals in all four directions.
    send_segment(0, 0, 63, 63);
    send_segment(63, 63, 0, 0);
    send_segment(0, 63, 63, 0);
    send_segment(63, 0, 0, 63);
    // Axis-aligned runs across the whole tile.
    send_segment(0, 5, 63, 5);
    send_segment(63, 5, 0, 5);
    send_segment(9, 0, 9, 63);
    send_segment(9, 63, 9, 0);
    // Single-pixel runs.
    send_segment(10, 10, 11, 10);
    send_segment(10, 10, 10, 9);
    send_segment(10, 10, 9, 11);
    // Shallow and steep slopes whose increments have long fractions.
    send_segment(0, 0, 63, 1);
    send_segment(0, 0, 1, 63);
    send_segment(63, 63, 0, 62);
    send_segment(0, 0, 62, 63);
    send_segment(0, 0, 63, 32);
    send_segment(5, 7, 48, 3);
    send_segment(3, 60, 62, 1);
    send_segment(1, 2, 50, 61);
  endtask

  task automatic test_random_segments(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        sender_idles   = ($urandom_range(0, 3) != 0);
        receiver_idles = ($urandom_range(0, 3) != 0);
      end
      send_random_segment();
    end
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  // Full rate on both sides, then a stalling receiver so the segment queue fills up.
  task automatic test_back_to_back(input int count);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) receiver_idles = 1'b1;
      send_random_segment();
    end
    sender_idles = 1'b1;
  endtask

  // Bursts separated by pauses in which every pixel drains before the next segment.
  task automatic test_drain_pause(input int bursts);
    for (int b = 0; b < bursts; b++) begin
      repeat (5) send_random_segment();
      wait_for_drain();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_segments();
    test_random_segments(160);
    test_back_to_back(100);
    test_drain_pause(4);
    test_random_segments(180);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
